// File: hw/rtl/svao_pkg.sv
package svao_pkg;

	localparam int PHASE_BITS = 32;
	localparam int TIME_BITS  = 24;
	localparam int NOTE_COUNT = 120;
	localparam int SINE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int NOTE_IDX_W = $clog2(NOTE_COUNT);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [63:0] E15         = 64'd1000000000000000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [31:0] LFSR_TAPS   = 32'h80200003;
	localparam logic [14:0] AMP_SCALE   = 15'd30000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_NOTE_ON = 2'd1,
		OP_NOTE_OFF = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		SH_SINE = 3'd0,
		SH_TRI = 3'd1,
		SH_SQUARE = 3'd2,
		SH_SAW = 3'd3,
		SH_NOISE = 3'd4
	} shape_t;

	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_WAVE,
		ST_AMP,
		ST_DONE
	} st_t;

	typedef logic [63:0] semi_tab_t [12];
	typedef logic [PHASE_BITS-1:0] note_tab_t [NOTE_COUNT];
	typedef logic signed [17:0] sine_tab_t [SINE_DEPTH];

	localparam semi_tab_t SEMI_RATIO_E15 = '{
		64'd1000000000000000, 64'd1059463094359295, 64'd1122462048309373,
		64'd1189207115002721, 64'd1259921049894873, 64'd1334839854170034,
		64'd1414213562373095, 64'd1498307076876681, 64'd1587401051968199,
		64'd1681792830507429, 64'd1781797436280678, 64'd1887748625363386
	};

	function automatic logic [63:0] scaled_div(input logic [63:0] x, input int s);
		logic [63:0] q;
		logic [63:0] r;
		q = x / E15;
		r = x % E15;
		for (int i = 0; i < s; i++) begin
			q = {q[62:0], 1'b0};
			r = {r[62:0], 1'b0};
			if (r >= E15) begin
				r = r - E15;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] series_div(input logic [63:0] t, input int k);
		logic [63:0] res;
		case (k)
			1: res = t / 64'd6;
			2: res = t / 64'd20;
			3: res = t / 64'd42;
			4: res = t / 64'd72;
			5: res = t / 64'd110;
			6: res = t / 64'd156;
			7: res = t / 64'd210;
			8: res = t / 64'd272;
			9: res = t / 64'd342;
			default: res = t / 64'd420;
		endcase
		return res;
	endfunction

	// Taylor series of sin in Q30
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 10; k++) begin
			term = (term * x2) >> 30;
			term = series_div(term, k);
			if (k % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	function automatic note_tab_t build_note_tab();
		note_tab_t tab;
		logic [63:0] x;
		logic [63:0] big;
		logic [63:0] v;
		int m;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			m = n + 3;
			x = SEMI_RATIO_E15[m % 12] * 64'd11;
			big = scaled_div(x, PHASE_BITS + m / 12 + 16);
			v = ((big / 64'd35280) + 64'd32768) >> 16;
			tab[n] = v[PHASE_BITS-1:0];
		end
		return tab;
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		logic [63:0] i4;
		logic [63:0] quad;
		logic [63:0] rem;
		logic [63:0] frac;
		logic [63:0] v;
		for (int n = 0; n < SINE_DEPTH; n++) begin
			i4 = 64'(4 * n);
			quad = i4 / SINE_DEPTH;
			rem = i4 % SINE_DEPTH;
			frac = quad[0] ? (64'(SINE_DEPTH) - rem) : rem;
			v = (sin_q30((HALF_PI_Q30 * frac) / SINE_DEPTH) + 64'd8192) >> 14;
			if (v > 64'd65536) v = 64'd65536;
			tab[n] = (quad >= 64'd2) ? -$signed({1'b0, v[16:0]}) : $signed({1'b0, v[16:0]});
		end
		return tab;
	endfunction

	localparam note_tab_t NOTE_STEP = build_note_tab();
	localparam sine_tab_t SINE_TAB  = build_sine_tab();

endpackage

// File: hw/rtl/synth_voice_adsr_oscillator.sv
// One synthesizer voice: note table, phase-accumulator oscillator (sine, triangle, square,
// saw, noise) and a linear ADSR envelope. Note-on and note-off items give no result. A tick
// item gives one sample; in attack, decay or release it passes setup, multiply, divide, sum,
// wave, amp and done, in sustain it skips multiply, divide and sum, the tick that finds the
// release run out goes from setup to done and a silent voice goes straight to done. A 17-step
// restoring divider after its own multiplier forms the envelope slope; waveform and output
// scaling have multipliers of their own. The voice takes no new item while a tick is in work.
// Configuration writes are accepted every cycle and must only come while the voice is idle.
module synth_voice_adsr_oscillator (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [svao_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [svao_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] op,
	input  logic [3:0] octave,
	input  logic [3:0] semitone,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] sample,
	output logic voice_active
);
	import svao_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	st_t state_q, state_d;

	logic [2:0] wave_shape_q;
	logic [TIME_BITS-1:0] attack_q, decay_q, release_q;
	logic [15:0] sustain_q;

	logic [PHASE_BITS-1:0] phase_acc_q, phase_step_q;
	logic [TIME_BITS-1:0] elapsed_q, rel_start_q;
	logic trig_q, rel_q, fin_q;
	logic [31:0] lfsr_q;

	logic [16:0] mul_n_q;
	logic [TIME_BITS-1:0] mul_m_q, div_d_q;
	logic [16:0] env_base_q, quo_q, env_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [4:0] cnt_q;
	logic [32:0] amp_q;
	logic wneg_q, silent_q;
	logic [15:0] mag_q;

	logic signed [15:0] sample_q;
	logic out_valid_q, active_q;

	logic accept, tick_live, done_fire, div_last;
	logic [TIME_BITS-1:0] a_eff, d_eff, r_eff, e_since_a, e_since_rel;
	logic rel_mode, in_attack, in_decay, in_release;
	logic [TIME_BITS:0] ad_sum;
	logic [TIME_BITS-1:0] off_start;
	logic [7:0] note_idx;
	logic held;
	logic [40:0] prod_nm;
	logic [TIME_BITS:0] div_t;
	logic div_ge;
	logic [15:0] u;
	logic signed [19:0] wave;
	logic [19:0] wave_abs;
	logic [47:0] scaled;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign voice_active = active_q;
	assign accept = in_valid && !in_stall;
	assign tick_live = trig_q && !fin_q;

	// envelope region
	always_comb begin
		a_eff = (attack_q == '0) ? TIME_BITS'(1) : attack_q;
		d_eff = (decay_q == '0) ? TIME_BITS'(1) : decay_q;
		r_eff = (release_q == '0) ? TIME_BITS'(1) : release_q;
		e_since_a = elapsed_q - a_eff;
		e_since_rel = elapsed_q - rel_start_q;
		rel_mode = rel_q && !(rel_start_q > elapsed_q);
		in_attack = !rel_mode && (elapsed_q <= a_eff);
		in_decay = !rel_mode && !in_attack && (e_since_a <= d_eff);
		in_release = rel_mode && (e_since_rel <= r_eff);
	end

	// note on / off helpers
	always_comb begin
		ad_sum = {1'b0, attack_q} + {1'b0, decay_q};
		if ({1'b0, elapsed_q} > ad_sum) off_start = elapsed_q;
		else if (ad_sum[TIME_BITS]) off_start = TIME_MAX;
		else off_start = ad_sum[TIME_BITS-1:0];
		note_idx = {4'd0, octave} * 8'd12 + {4'd0, semitone};
		held = trig_q && (!rel_q || (elapsed_q < rel_start_q));
	end

	// envelope multiplier, divider step and output scaling
	always_comb begin
		prod_nm = {24'd0, mul_n_q} * {17'd0, mul_m_q};
		div_t = {rem_q, quo_q[16]};
		div_ge = div_t >= {1'b0, div_d_q};
		div_last = (cnt_q == 5'd16);
		scaled = {15'd0, amp_q} * {33'd0, AMP_SCALE};
	end

	// waveform
	always_comb begin
		u = phase_acc_q[PHASE_BITS-1 -: 16];
		case (wave_shape_q)
			SH_SINE: wave = 20'(SINE_TAB[phase_acc_q[PHASE_BITS-1 -: SINE_IDX_W]]);
			SH_TRI: begin
				if (u <= 16'd16384) wave = $signed({2'b00, u, 2'b00});
				else if (u <= 16'd49152) wave = 20'sd131072 - $signed({2'b00, u, 2'b00});
				else wave = $signed({2'b00, u, 2'b00}) - 20'sd262144;
			end
			SH_SQUARE: wave = (u < 16'd32768) ? 20'sd65536 : -20'sd65536;
			SH_SAW: begin
				if (u <= 16'd32768) wave = $signed({3'b000, u, 1'b0});
				else wave = $signed({3'b000, u, 1'b0}) - 20'sd131072;
			end
			SH_NOISE: wave = $signed({3'b000, lfsr_q[31:15]}) - 20'sd65536;
			default: wave = '0;
		endcase
		wave_abs = wave[19] ? 20'(-wave) : wave;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_TICK) state_d = tick_live ? ST_SETUP : ST_DONE;
			end
			ST_SETUP: begin
				if (in_attack || in_decay || in_release) state_d = ST_MUL;
				else if (rel_mode) state_d = ST_DONE;
				else state_d = ST_WAVE;
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: if (div_last) state_d = ST_SUM;
			ST_SUM: state_d = ST_WAVE;
			ST_WAVE: state_d = ST_AMP;
			ST_AMP: state_d = ST_DONE;
			ST_DONE: if (done_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		done_fire = (state_q == ST_DONE) && !(out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wave_shape_q <= SH_SINE;
			attack_q <= TIME_BITS'(4410);
			decay_q <= TIME_BITS'(8820);
			sustain_q <= 16'd26214;
			release_q <= TIME_BITS'(17640);
			phase_acc_q <= '0;
			phase_step_q <= '0;
			elapsed_q <= '0;
			rel_start_q <= '0;
			trig_q <= 1'b0;
			rel_q <= 1'b0;
			fin_q <= 1'b0;
			lfsr_q <= 32'd1;
			out_valid_q <= 1'b0;
			silent_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WAVE_SHAPE: wave_shape_q <= cfg_data[2:0];
					CFG_ATTACK: attack_q <= cfg_data[TIME_BITS-1:0];
					CFG_DECAY: decay_q <= cfg_data[TIME_BITS-1:0];
					CFG_SUSTAIN: sustain_q <= cfg_data[15:0];
					CFG_RELEASE: release_q <= cfg_data[TIME_BITS-1:0];
					default: ;
				endcase
			end

			if (done_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_NOTE_ON: begin
								if (!held) begin
									if (note_idx < 8'(NOTE_COUNT))
										phase_step_q <= NOTE_STEP[note_idx[NOTE_IDX_W-1:0]];
									phase_acc_q <= '0;
									elapsed_q <= '0;
									rel_start_q <= '0;
									trig_q <= 1'b1;
									rel_q <= 1'b0;
									fin_q <= 1'b0;
								end
							end
							OP_NOTE_OFF: begin
								if (trig_q) begin
									rel_start_q <= off_start;
									rel_q <= 1'b1;
								end
							end
							OP_TICK: silent_q <= !tick_live;
							default: ;
						endcase
					end
				end
				ST_SETUP: begin
					// release ran out: silence until next note on
					if (rel_mode && !in_release) begin
						fin_q <= 1'b1;
						silent_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						if (elapsed_q != TIME_MAX) elapsed_q <= elapsed_q + 1'b1;
						phase_acc_q <= phase_acc_q + phase_step_q;
						lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP: begin
				if (in_attack) begin
					mul_n_q <= 17'd65536;
					mul_m_q <= elapsed_q;
					div_d_q <= a_eff;
					env_base_q <= '0;
				end else if (in_decay) begin
					mul_n_q <= 17'd65536 - {1'b0, sustain_q};
					mul_m_q <= d_eff - e_since_a;
					div_d_q <= d_eff;
					env_base_q <= {1'b0, sustain_q};
				end else begin
					mul_n_q <= {1'b0, sustain_q};
					mul_m_q <= r_eff - e_since_rel;
					div_d_q <= r_eff;
					env_base_q <= '0;
				end
				env_q <= {1'b0, sustain_q};
			end
			ST_MUL: begin
				rem_q <= prod_nm[40:17];
				quo_q <= prod_nm[16:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? TIME_BITS'(div_t - {1'b0, div_d_q}) : div_t[TIME_BITS-1:0];
				quo_q <= {quo_q[15:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SUM: env_q <= env_base_q + quo_q;
			ST_WAVE: begin
				amp_q <= {16'd0, env_q} * {16'd0, wave_abs[16:0]};
				wneg_q <= wave[19];
			end
			ST_AMP: mag_q <= scaled[47:32];
			ST_DONE: begin
				if (done_fire) begin
					if (silent_q) begin
						sample_q <= '0;
						active_q <= 1'b0;
					end else begin
						sample_q <= wneg_q ? -$signed(mag_q) : $signed(mag_q);
						active_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
